// File: rtl/uid_range_network_table_macros.svh
// Assertion macros for the uid range network table.
// Included by the top level; no other dependencies.
`ifndef UID_RANGE_NETWORK_TABLE_MACROS_SVH
`define UID_RANGE_NETWORK_TABLE_MACROS_SVH

// same-cycle implication under synchronous active-low reset
`define URNT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("urnt assertion failed");

// next-cycle implication under synchronous active-low reset
`define URNT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("urnt assertion failed");

`endif

// File: rtl/urnt_pkg.sv
// Package for the uid range network table: widths, codes and word types.
// No dependencies.
`timescale 1ns / 1ps

package urnt_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int UID_W         = 31;
    localparam int NET_W         = 16;
    localparam logic [NET_W-1:0] MIN_NET = NET_W'(10);

    typedef enum logic [1:0] {
        OP_SET       = 2'd0,
        OP_CLEAR     = 2'd1,
        OP_LOOKUP    = 2'd2,
        OP_CLEAR_ALL = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_ARGS  = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef struct packed {
        t_opcode          opcode;
        logic [UID_W-1:0] range_start;
        logic [UID_W-1:0] range_end;
        logic [NET_W-1:0] net_id;
        logic             dns_fwd_en;
        logic [UID_W-1:0] query_uid;
        logic [NET_W-1:0] requested_net_id;
        logic             for_dns;
    } t_in_word;

    typedef struct packed {
        t_status          status;
        logic [NET_W-1:0] result_net_id;
    } t_out_word;

    typedef struct packed {
        logic capture;
        logic compare;
        logic commit;
    } t_cmd;

endpackage

// File: rtl/urnt_ctrl.sv
// Controller for the uid range network table: capture, compare, commit sequence.
// Depends on urnt_pkg.
`timescale 1ns / 1ps

module urnt_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output urnt_pkg::t_cmd  o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_UPD
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = !((r_state == S_IDLE) || ((r_state == S_UPD) && out_free));
    assign o_out_valid = r_out_valid;

    assign o_cmd.capture = i_in_valid && !o_in_stall;
    assign o_cmd.compare = (r_state == S_CMP);
    assign o_cmd.commit  = (r_state == S_UPD) && out_free;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (o_cmd.capture) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                n_state = S_UPD;
            end
            S_UPD: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_state     = o_cmd.capture ? S_CMP : S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// File: rtl/urnt_dpath.sv
// Datapath for the uid range network table: entry rows, parallel compare, update, result word.
// Depends on urnt_pkg.
`timescale 1ns / 1ps

module urnt_dpath #(
    parameter int TABLE_ENTRIES = urnt_pkg::TABLE_ENTRIES
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  urnt_pkg::t_cmd             i_cmd,
    input  urnt_pkg::t_in_word         i_in_data,
    input  logic                       i_cfg_we,
    input  logic [urnt_pkg::NET_W-1:0] i_cfg_data,
    output urnt_pkg::t_out_word        o_out_data
);

    localparam int UW = urnt_pkg::UID_W;
    localparam int NW = urnt_pkg::NET_W;
    localparam logic [TABLE_ENTRIES-1:0] ONE_N = TABLE_ENTRIES'(1);

    urnt_pkg::t_in_word  r_in;
    urnt_pkg::t_out_word r_out, n_out;
    logic [NW-1:0]       r_default;

    logic [UW-1:0] r_start [TABLE_ENTRIES];
    logic [UW-1:0] r_end   [TABLE_ENTRIES];
    logic [NW-1:0] r_net   [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] r_dns;
    logic [TABLE_ENTRIES-1:0] r_valid;

    logic [UW-1:0] n_start [TABLE_ENTRIES];
    logic [UW-1:0] n_end   [TABLE_ENTRIES];
    logic [NW-1:0] n_net   [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] n_dns;
    logic [TABLE_ENTRIES-1:0] n_valid;

    logic [TABLE_ENTRIES-1:0] r_exact, n_exact;
    logic [TABLE_ENTRIES-1:0] r_rhit, n_rhit;
    logic                     r_args_ok, n_args_ok;

    logic [TABLE_ENTRIES-1:0] first_hit;
    logic [TABLE_ENTRIES-1:0] tail_mask;
    logic                     exact_any;
    logic                     range_any;
    logic                     sel_dns;
    logic [NW-1:0]            sel_net;
    logic [NW-1:0]            fallback;

    // compare stage
    always_comb begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            n_exact[i] = r_valid[i] && (r_start[i] == r_in.range_start)
                         && (r_end[i] == r_in.range_end) && (r_net[i] == r_in.net_id);
            n_rhit[i]  = r_valid[i] && (r_start[i] <= r_in.query_uid)
                         && (r_in.query_uid <= r_end[i]);
        end
        n_args_ok = (r_in.range_start <= r_in.range_end) && (r_in.net_id >= urnt_pkg::MIN_NET);
    end

    // commit stage
    assign first_hit = r_rhit & (~r_rhit + ONE_N);
    assign tail_mask = ~(r_exact - ONE_N);
    assign exact_any = |r_exact;
    assign range_any = |r_rhit;
    assign sel_dns   = |(first_hit & r_dns);
    assign fallback  = (r_in.requested_net_id >= urnt_pkg::MIN_NET) ?
                       r_in.requested_net_id : r_default;

    always_comb begin
        sel_net = '0;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            sel_net = sel_net | (r_net[i] & {NW{first_hit[i]}});
        end
    end

    always_comb begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            n_start[i] = r_start[i];
            n_end[i]   = r_end[i];
            n_net[i]   = r_net[i];
        end
        n_dns   = r_dns;
        n_valid = r_valid;
        n_out.status        = urnt_pkg::ST_OK;
        n_out.result_net_id = '0;
        unique case (r_in.opcode)
            urnt_pkg::OP_SET: begin
                if (!r_args_ok) begin
                    n_out.status = urnt_pkg::ST_BAD_ARGS;
                end else if (exact_any) begin
                    n_dns = (r_dns & ~r_exact) | (r_exact & {TABLE_ENTRIES{r_in.dns_fwd_en}});
                end else if (r_valid[TABLE_ENTRIES-1]) begin
                    n_out.status = urnt_pkg::ST_FULL;
                end else begin
                    for (int i = TABLE_ENTRIES - 1; i > 0; i--) begin
                        n_start[i] = r_start[i-1];
                        n_end[i]   = r_end[i-1];
                        n_net[i]   = r_net[i-1];
                        n_dns[i]   = r_dns[i-1];
                        n_valid[i] = r_valid[i-1];
                    end
                    n_start[0] = r_in.range_start;
                    n_end[0]   = r_in.range_end;
                    n_net[0]   = r_in.net_id;
                    n_dns[0]   = r_in.dns_fwd_en;
                    n_valid[0] = 1'b1;
                end
            end
            urnt_pkg::OP_CLEAR: begin
                if (!r_args_ok) begin
                    n_out.status = urnt_pkg::ST_BAD_ARGS;
                end else if (!exact_any) begin
                    n_out.status = urnt_pkg::ST_NOT_FOUND;
                end else begin
                    for (int i = 0; i + 1 < TABLE_ENTRIES; i++) begin
                        if (tail_mask[i]) begin
                            n_start[i] = r_start[i+1];
                            n_end[i]   = r_end[i+1];
                            n_net[i]   = r_net[i+1];
                            n_dns[i]   = r_dns[i+1];
                        end
                        n_valid[i] = r_valid[i+1];
                    end
                    n_valid[TABLE_ENTRIES-1] = 1'b0;
                end
            end
            urnt_pkg::OP_LOOKUP: begin
                if (range_any && !(r_in.for_dns && !sel_dns)) begin
                    n_out.result_net_id = sel_net;
                end else begin
                    n_out.result_net_id = fallback;
                end
            end
            urnt_pkg::OP_CLEAR_ALL: begin
                n_valid = '0;
            end
            default: begin
                n_valid = r_valid;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_in <= i_in_data;
        end
        if (i_cmd.compare) begin
            r_exact   <= n_exact;
            r_rhit    <= n_rhit;
            r_args_ok <= n_args_ok;
        end
        if (i_cmd.commit) begin
            r_out <= n_out;
            r_dns <= n_dns;
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                r_start[i] <= n_start[i];
                r_end[i]   <= n_end[i];
                r_net[i]   <= n_net[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_default <= '0;
        end else begin
            if (i_cmd.commit) begin
                r_valid <= n_valid;
            end
            if (i_cfg_we) begin
                r_default <= i_cfg_data;
            end
        end
    end

    assign o_out_data = r_out;

endmodule

// File: rtl/uid_range_network_table.sv
// An accepted word is captured, then compared against all rows, then its update is committed
// and its result word registered. No new word is taken while the previous one is compared,
// nor while its result waits on a stalled result register.
// Reset: synchronous, active low; empties the table and clears default_net_id to 0.
// Top level of the uid range network table; joins urnt_ctrl and urnt_dpath.
// Depends on urnt_pkg and uid_range_network_table_macros.svh.
`timescale 1ns / 1ps
`include "uid_range_network_table_macros.svh"

module uid_range_network_table #(
    parameter int TABLE_ENTRIES = urnt_pkg::TABLE_ENTRIES
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  urnt_pkg::t_in_word         i_in_data,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output urnt_pkg::t_out_word        o_out_data,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [urnt_pkg::NET_W-1:0] i_cfg_data
);

    urnt_pkg::t_cmd cmd;

    assign o_cfg_ready = 1'b1;

    urnt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd)
    );

    urnt_dpath #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_in_data  (i_in_data),
        .i_cfg_we   (i_cfg_valid && o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .o_out_data (o_out_data)
    );

    `URNT_ASSERT_NEXT(a_capture_then_compare, i_clk, i_rst_n, cmd.capture, cmd.compare)
    `URNT_ASSERT_NOW(a_no_accept_in_compare, i_clk, i_rst_n, cmd.compare, o_in_stall)
    `URNT_ASSERT_NEXT(a_compare_then_commit, i_clk, i_rst_n, cmd.compare,
                      cmd.commit || (o_out_valid && i_out_stall))
    `URNT_ASSERT_NEXT(a_commit_presents_word, i_clk, i_rst_n, cmd.commit, o_out_valid)

endmodule
